// ===== hdl/encoder_position_move_controller_macros.svh =====
// Assertion macros for the move controller RTL
`ifndef ENCODER_POSITION_MOVE_CONTROLLER_MACROS_SVH
`define ENCODER_POSITION_MOVE_CONTROLLER_MACROS_SVH

// Condition that must hold in the same cycle
`define EPMC_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger in one cycle, consequence in the next
`define EPMC_CHECK_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/epmc_pkg.sv =====
// Package: codes, widths and constants of the encoder move controller
`timescale 1ns / 1ps
package epmc_pkg;

    localparam int MODE_W   = 2;
    localparam int INCR_W   = 24;
    localparam int DRIVE_W  = 8;
    localparam int GAIN_W   = 8;
    localparam int LIMIT_W  = 7;
    localparam int STALL_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 8'd7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [STALL_W-1:0] STALL_RESET = 16'd10;

    localparam int POSITION_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // start sets previous position this far below the count
    localparam int START_PREV_OFFSET = 10;

    // magnitude at which gain*mag/10 exceeds any limit for a nonzero gain
    localparam int SAT_MAG = 1280;
    localparam int MAG_W   = 11;
    localparam int PROD_W  = GAIN_W + MAG_W;

    // x/10 == (x*DIV10_RECIP) >> DIV10_SHIFT, exact for x < 2**PROD_W
    localparam int DIV10_SHIFT = 22;
    localparam logic [PROD_W-1:0] DIV10_RECIP = 19'd419431;
    localparam int QUOT_W = 16;

    typedef struct packed {
        logic push;
        logic ending;
    } tick_ctl_t;

endpackage

// ===== hdl/epmc_if.sv =====
// Channel interfaces: input items and drive results
`timescale 1ns / 1ps
interface epmc_in_if
    import epmc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [INCR_W-1:0] increment;
    logic                     direction_up;

    modport source (output valid, output mode, output increment, output direction_up,
                    input ready);
    modport sink (input valid, input mode, input increment, input direction_up,
                  output ready);
endinterface

interface epmc_out_if
    import epmc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    logic                      done_res;
    logic                      last_of_run;

    modport source (output valid, output drive, output done_res, output last_of_run,
                    input ready);
    modport sink (input valid, input drive, input done_res, input last_of_run,
                  output ready);
endinterface

// ===== hdl/epmc_front.sv =====
// Front end: accepts items, tracks position and stall state, queues tick jobs
`timescale 1ns / 1ps
module epmc_front
    import epmc_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    epmc_in_if.sink                   in_ch,
    input  logic [STALL_W-1:0]        stall_ticks,
    input  logic                      q_full,
    output tick_ctl_t                 push_ctl,
    output logic [POSITION_WIDTH-1:0] push_err,
    output logic                      moving
);

    localparam int PW = POSITION_WIDTH;

    logic [PW-1:0]      position_reg, position_next;
    logic [PW-1:0]      target_reg, target_next;
    logic [PW-1:0]      previous_reg, previous_next;
    logic               moving_reg, moving_next;
    logic               stall_seen_reg, stall_seen_next;
    logic [STALL_W-1:0] ticks_reg, ticks_next;

    logic               accept;
    logic [PW+INCR_W-1:0] inc_wide;
    logic [PW-1:0]      inc_ext;
    logic [STALL_W-1:0] tick_incr;
    logic               unchanged;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign inc_wide    = {{PW{in_ch.increment[INCR_W-1]}}, in_ch.increment};
    assign inc_ext     = inc_wide[PW-1:0];
    assign unchanged   = (previous_reg == position_reg);
    assign tick_incr   = (stall_seen_reg && ticks_reg != {STALL_W{1'b1}})
                         ? ticks_reg + STALL_W'(1) : ticks_reg;
    assign push_err    = target_reg - position_reg;
    assign moving      = moving_reg;

    always_comb
    begin
        position_next   = position_reg;
        target_next     = target_reg;
        previous_next   = previous_reg;
        moving_next     = moving_reg;
        stall_seen_next = stall_seen_reg;
        ticks_next      = ticks_reg;
        push_ctl        = '0;
        if (accept)
        begin
            unique case (in_ch.mode)
                MODE_START:
                begin
                    target_next     = position_reg + inc_ext;
                    previous_next   = position_reg - PW'(START_PREV_OFFSET);
                    moving_next     = 1'b1;
                    stall_seen_next = 1'b0;
                    ticks_next      = '0;
                end
                MODE_EDGE:
                begin
                    position_next = in_ch.direction_up ? position_reg + PW'(1)
                                                       : position_reg - PW'(1);
                end
                MODE_TICK:
                begin
                    if (moving_reg)
                    begin
                        push_ctl.push = 1'b1;
                        previous_next = position_reg;
                        ticks_next    = tick_incr;
                        if (unchanged)
                        begin
                            if (!stall_seen_reg)
                            begin
                                stall_seen_next = 1'b1;
                                ticks_next      = '0;
                            end
                            else if (tick_incr > stall_ticks)
                            begin
                                // stalled too long: move ends after this drive
                                push_ctl.ending = 1'b1;
                                moving_next     = 1'b0;
                                stall_seen_next = 1'b0;
                                ticks_next      = '0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            target_reg     <= '0;
            previous_reg   <= '0;
            moving_reg     <= 1'b0;
            stall_seen_reg <= 1'b0;
            ticks_reg      <= '0;
        end
        else
        begin
            position_reg   <= position_next;
            target_reg     <= target_next;
            previous_reg   <= previous_next;
            moving_reg     <= moving_next;
            stall_seen_reg <= stall_seen_next;
            ticks_reg      <= ticks_next;
        end
    end

endmodule

// ===== hdl/epmc_queue.sv =====
// Short FIFO of tick jobs between front end and drive pipeline
`timescale 1ns / 1ps
module epmc_queue
    import epmc_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tick_ctl_t                 push_ctl,
    input  logic [POSITION_WIDTH-1:0] push_err,
    output logic                      full,
    output logic                      pop_valid,
    output logic [POSITION_WIDTH-1:0] pop_err,
    output logic                      pop_ending,
    input  logic                      pop
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [POSITION_WIDTH-1:0] err_mem [QUEUE_DEPTH];
    logic                      end_mem [QUEUE_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_err    = err_mem[rd_ptr_reg];
    assign pop_ending = end_mem[rd_ptr_reg];
    assign do_push    = push_ctl.push && !full;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            err_mem[wr_ptr_reg] <= push_err;
            end_mem[wr_ptr_reg] <= push_ctl.ending;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/epmc_back.sv =====
// Back end: gain, divide by ten, clamp, and the result output register
`timescale 1ns / 1ps
module epmc_back
    import epmc_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  logic [POSITION_WIDTH-1:0] q_err,
    input  logic                      q_ending,
    output logic                      q_pop,
    input  logic [GAIN_W-1:0]         gain_tenths,
    input  logic [LIMIT_W-1:0]        drive_limit,
    epmc_out_if.source                out_ch
);

    localparam int PW = POSITION_WIDTH;

    // stage A: magnitude and gain product
    logic              sa_valid_reg, sa_valid_next;
    logic [PROD_W-1:0] sa_prod_reg;
    logic              sa_big_reg;
    logic              sa_neg_reg;
    logic              sa_end_reg;

    // output register, with a pending done result behind an ending drive
    logic               ov_reg, ov_next;
    logic               pend_reg, pend_next;
    logic [DRIVE_W-1:0] drive_reg, drive_next;
    logic               done_reg, done_next;
    logic               last_reg, last_next;

    logic [PW-1:0]          mag;
    logic                   out_load, sa_load;
    logic [2*PROD_W-1:0]    recip_prod;
    logic [QUOT_W-1:0]      quot;
    logic [LIMIT_W-1:0]     clamped;
    logic [DRIVE_W-1:0]     drive_mag;

    assign mag = q_err[PW-1] ? (PW'(0) - q_err) : q_err;

    assign out_load = sa_valid_reg && (!ov_reg || (out_ch.ready && !pend_reg));
    assign sa_load  = q_valid && (!sa_valid_reg || out_load);
    assign q_pop    = sa_load;

    assign recip_prod = (2*PROD_W)'(sa_prod_reg) * (2*PROD_W)'(DIV10_RECIP);
    assign quot       = recip_prod[DIV10_SHIFT +: QUOT_W];

    always_comb
    begin
        if (sa_big_reg)
            clamped = (gain_tenths != '0) ? drive_limit : '0;
        else if (quot > QUOT_W'(drive_limit))
            clamped = drive_limit;
        else
            clamped = quot[LIMIT_W-1:0];
    end

    assign drive_mag = {1'b0, clamped};

    always_comb
    begin
        sa_valid_next = sa_valid_reg;
        if (sa_load)
            sa_valid_next = 1'b1;
        else if (out_load)
            sa_valid_next = 1'b0;
    end

    always_comb
    begin
        ov_next    = ov_reg;
        pend_next  = pend_reg;
        drive_next = drive_reg;
        done_next  = done_reg;
        last_next  = last_reg;
        if (out_load)
        begin
            ov_next    = 1'b1;
            drive_next = sa_neg_reg ? (DRIVE_W'(0) - drive_mag) : drive_mag;
            done_next  = 1'b0;
            last_next  = !sa_end_reg;
            pend_next  = sa_end_reg;
        end
        else if (ov_reg && out_ch.ready)
        begin
            if (pend_reg)
            begin
                drive_next = '0;
                done_next  = 1'b1;
                last_next  = 1'b1;
                pend_next  = 1'b0;
            end
            else
                ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sa_load)
        begin
            sa_prod_reg <= PROD_W'(gain_tenths) * PROD_W'(mag[MAG_W-1:0]);
            sa_big_reg  <= (mag >= PW'(SAT_MAG));
            sa_neg_reg  <= q_err[PW-1];
            sa_end_reg  <= q_ending;
        end
        drive_reg <= drive_next;
        done_reg  <= done_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
            ov_reg       <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            sa_valid_reg <= sa_valid_next;
            ov_reg       <= ov_next;
            pend_reg     <= pend_next;
        end
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.drive       = drive_reg;
    assign out_ch.done_res    = done_reg;
    assign out_ch.last_of_run = last_reg;

endmodule

// ===== hdl/encoder_position_move_controller.sv =====
// Encoder move controller: one item per cycle in while the tick queue has room;
// each control tick while a move is active yields a clamped proportional drive
// via the queue write, gain stage, and divide-by-ten and clamp into the output
// register. Encoder edges, start items and idle ticks give no result. A tick that
// ends a move on stall gives two results on consecutive output transfers, the
// drive and then a zero drive marked done, holding the output for both; the tick
// queue (QUEUE_DEPTH entries) absorbs the difference while input keeps flowing.
`timescale 1ns / 1ps
`include "encoder_position_move_controller_macros.svh"
module encoder_position_move_controller
    import epmc_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    epmc_in_if.sink               in_ch,
    epmc_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [GAIN_W-1:0]  gain_reg, gain_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [STALL_W-1:0] stall_reg, stall_next;

    tick_ctl_t                 push_ctl;
    logic [POSITION_WIDTH-1:0] push_err;
    logic                      q_full;
    logic                      q_valid;
    logic [POSITION_WIDTH-1:0] q_err;
    logic                      q_ending;
    logic                      q_pop;
    logic                      moving;

    always_comb
    begin
        gain_next  = gain_reg;
        limit_next = limit_reg;
        stall_next = stall_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN:  gain_next  = cfg_data[GAIN_W-1:0];
                CFG_LIMIT: limit_next = cfg_data[LIMIT_W-1:0];
                CFG_STALL: stall_next = cfg_data[STALL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            limit_reg <= LIMIT_RESET;
            stall_reg <= STALL_RESET;
        end
        else
        begin
            gain_reg  <= gain_next;
            limit_reg <= limit_next;
            stall_reg <= stall_next;
        end
    end

    epmc_front #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .stall_ticks(stall_reg),
        .q_full     (q_full),
        .push_ctl   (push_ctl),
        .push_err   (push_err),
        .moving     (moving)
    );

    epmc_queue #(
        .POSITION_WIDTH(POSITION_WIDTH),
        .QUEUE_DEPTH   (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_ctl  (push_ctl),
        .push_err  (push_err),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_err   (q_err),
        .pop_ending(q_ending),
        .pop       (q_pop)
    );

    epmc_back #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_err      (q_err),
        .q_ending   (q_ending),
        .q_pop      (q_pop),
        .gain_tenths(gain_reg),
        .drive_limit(limit_reg),
        .out_ch     (out_ch)
    );

    // a done result is a zero drive closing its run
    `EPMC_CHECK(a_done_is_zero_last, !(out_ch.valid && out_ch.done_res) || (out_ch.drive == '0 && out_ch.last_of_run), "done result must be zero drive and last")

    // a drive that is not last is followed at once by the done result
    `EPMC_CHECK_NEXT(a_done_follows, out_ch.valid && out_ch.ready && !out_ch.last_of_run, out_ch.valid && out_ch.done_res, "missing done result after ending drive")

    // drive stays inside the clamp
    `EPMC_CHECK(a_drive_clamped, !out_ch.valid || ($signed(out_ch.drive) <= $signed({1'b0, limit_reg}) && $signed(out_ch.drive) >= -$signed({1'b0, limit_reg})), "drive outside clamp")

    // an idle tick queues nothing
    `EPMC_CHECK(a_idle_tick_no_job, !(push_ctl.push && !moving), "tick job queued while idle")

endmodule
